@@ hdl/m127_pkg.sv @@
// ---------------------------------------------------------------------------
// m127_pkg: shared constants and helpers for the 2^127-1 field unit
// Field width, operation codes and the modular add used by every stage.
// ---------------------------------------------------------------------------
package m127_pkg;

	localparam int unsigned FeW = 127;
	localparam int unsigned LoW = 64;
	localparam int unsigned HiW = 63;
	localparam int unsigned CntW = 7;

	typedef logic [FeW-1:0] fe_t;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_POW = 3'd3;
	localparam logic [2:0] OP_INV = 3'd4;

	localparam fe_t FE_P   = {FeW{1'b1}};
	localparam fe_t FE_ONE = {{(FeW-1){1'b0}}, 1'b1};
	localparam fe_t FE_PM2 = {{(FeW-2){1'b1}}, 2'b01};
	localparam logic [CntW-1:0] LAST_BIT = CntW'(FeW - 1);

	// Sum modulo p: the carry out of bit 126 wraps around as +1, and p itself
	// is replaced by zero so the result is always canonical.
	function automatic fe_t add_mod(fe_t a, fe_t b);
		logic [FeW:0] s;
		fe_t t;
		s = {1'b0, a} + {1'b0, b};
		t = s[FeW-1:0] + fe_t'(s[FeW]);
		return (t == FE_P) ? '0 : t;
	endfunction

endpackage

@@ hdl/m127_mul.sv @@
// ---------------------------------------------------------------------------
// m127_mul: bit-serial modular multiplier
// Scans the multiplier MSB first, one bit per cycle: the accumulator is
// doubled (a rotate, since 2^127 = 1 mod p) and the multiplicand added.
// ---------------------------------------------------------------------------
module m127_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  m127_pkg::fe_t    x,
	input  m127_pkg::fe_t    y,
	output logic             done,
	output m127_pkg::fe_t    prod
);
	import m127_pkg::*;

	fe_t acc_q, x_q, y_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q, done_q;
	fe_t step;

	always_comb begin
		step = add_mod({acc_q[FeW-2:0], acc_q[FeW-1]}, y_q[FeW-1] ? x_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= step;
			y_q   <= {y_q[FeW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ hdl/mersenne127_field_alu.sv @@
// ---------------------------------------------------------------------------
// mersenne127_field_alu: arithmetic unit for the field modulo 2^127-1
// Add, subtract, multiply, power and inverse on 127-bit field elements.
// ---------------------------------------------------------------------------
// Usage: a request (req_type, a_lo/a_hi, b_lo/b_hi) is taken when in_valid
// and in_ready are both high; exactly one result (res_lo/res_hi) follows on
// the out_valid/out_ready channel. The unit works on one request at a time;
// in_ready is high while it is idle, also while a result waits to be taken.
// Add, subtract and unknown operations go straight to the output stage. A
// multiply runs on the bit-serial multiplier: it is started, takes one
// multiplier bit per step through all 127 bits, and hands the product back.
// Power squares for each of the 127 exponent bits and adds a multiply by
// the base for each set bit; inverse uses the exponent p-2.
// A stalled receiver holds the result in the output register; a finished
// computation waits until that register is free.
// Reset clears the control state and drops out_valid; no result survives it.
// ---------------------------------------------------------------------------
module mersenne127_field_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    req_type,
	input  logic [m127_pkg::LoW-1:0]      a_lo,
	input  logic [m127_pkg::HiW-1:0]      a_hi,
	input  logic [m127_pkg::LoW-1:0]      b_lo,
	input  logic [m127_pkg::HiW-1:0]      b_hi,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [m127_pkg::LoW-1:0]      res_lo,
	output logic [m127_pkg::HiW-1:0]      res_hi
);
	import m127_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SQ   = 5'b00100,
		ST_PM   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t st_q;
	fe_t r_q, base_q, e_q, out_q;
	logic [CntW-1:0] ecnt_q;
	logic run_q, ov_q;
	logic mul_start, mul_done;
	fe_t mul_x, mul_y, prod, a_in, b_in;

	assign a_in = {a_hi, a_lo};
	assign b_in = {b_hi, b_lo};
	assign in_ready = (st_q == ST_IDLE);
	assign mul_start = !run_q && (st_q == ST_MUL || st_q == ST_SQ || st_q == ST_PM);

	always_comb begin
		unique case (st_q)
			ST_SQ: begin
				mul_x = r_q;
				mul_y = r_q;
			end
			ST_PM: begin
				mul_x = base_q;
				mul_y = r_q;
			end
			default: begin
				mul_x = base_q;
				mul_y = e_q;
			end
		endcase
	end

	m127_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.x     (mul_x),
		.y     (mul_y),
		.done  (mul_done),
		.prod  (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			run_q  <= 1'b0;
			ov_q   <= 1'b0;
			ecnt_q <= '0;
		end else begin
			if (st_q == ST_FIN && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			if (mul_start) run_q <= 1'b1;
			if (mul_done) run_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						ecnt_q <= '0;
						if (req_type == OP_MUL) st_q <= ST_MUL;
						else if (req_type == OP_POW || req_type == OP_INV) st_q <= ST_SQ;
						else st_q <= ST_FIN;
					end
				end
				ST_MUL: begin
					if (mul_done) st_q <= ST_FIN;
				end
				ST_SQ: begin
					if (mul_done) begin
						if (e_q[FeW-1]) st_q <= ST_PM;
						else begin
							ecnt_q <= ecnt_q + 1'b1;
							st_q <= (ecnt_q == LAST_BIT) ? ST_FIN : ST_SQ;
						end
					end
				end
				ST_PM: begin
					if (mul_done) begin
						ecnt_q <= ecnt_q + 1'b1;
						st_q <= (ecnt_q == LAST_BIT) ? ST_FIN : ST_SQ;
					end
				end
				ST_FIN: begin
					if (!ov_q || out_ready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				base_q <= a_in;
				e_q    <= (req_type == OP_INV) ? FE_PM2 : b_in;
				if (req_type == OP_ADD) r_q <= add_mod(a_in, b_in);
				else if (req_type == OP_SUB) r_q <= add_mod(a_in, ~b_in);
				else if (req_type == OP_POW || req_type == OP_INV) r_q <= FE_ONE;
				else r_q <= '0;
			end
			ST_MUL: begin
				if (mul_done) r_q <= prod;
			end
			ST_SQ: begin
				if (mul_done) begin
					r_q <= prod;
					if (!e_q[FeW-1]) e_q <= {e_q[FeW-2:0], 1'b0};
				end
			end
			ST_PM: begin
				if (mul_done) begin
					r_q <= prod;
					e_q <= {e_q[FeW-2:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (!ov_q || out_ready) out_q <= r_q;
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign res_lo = out_q[LoW-1:0];
	assign res_hi = out_q[FeW-1:LoW];

endmodule
